// ----- rtl/core/hpl_pkg.sv -----
package hpl_pkg;

  // result kinds
  localparam logic [1:0] KIND_RECORD = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // what one accepted item asks for
  typedef enum logic [2:0] {
    EV_NONE,
    EV_FAIL,
    EV_PATCH,
    EV_ACCEPT,
    EV_SILENT
  } hpl_ev_e;

  typedef struct packed {
    logic step;
    logic chk;
    logic scan_en;
    logic emit;
    logic rec_last;
    logic ld_err;
    logic ld_acc;
    logic line_inc;
    logic clear;
  } hpl_cmd_t;

  typedef struct packed {
    hpl_ev_e ev;
    logic    full;
    logic    zero_pairs;
    logic    hit;
    logic    scan_done;
    logic    emit_last;
    logic    out_free;
  } hpl_sts_t;

endpackage

// ----- rtl/core/hpl_ctrl.sv -----
module hpl_ctrl import hpl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic     mode_i,
  input  hpl_sts_t sts_i,
  output hpl_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_EMIT   = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;
  localparam logic [2:0] S_ACC    = 3'd5;
  localparam logic [2:0] S_FAIL   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       eof_q, eof_d;
  logic       accept;

  assign in_stall_o = !((state_q == S_IDLE) && sts_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    eof_d   = eof_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.step = 1'b1;
          case (sts_i.ev)
            EV_FAIL: begin
              cmd_o.ld_err = 1'b1;
              cmd_o.clear  = mode_i;
            end
            EV_ACCEPT: begin
              cmd_o.ld_acc = 1'b1;
              cmd_o.clear  = 1'b1;
            end
            EV_SILENT: cmd_o.clear = 1'b1;
            EV_PATCH: begin
              eof_d   = mode_i;
              state_d = S_CHECK;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        cmd_o.chk = 1'b1;
        if (sts_i.full) begin
          state_d = S_FAIL;
        end else if (sts_i.zero_pairs) begin
          state_d = S_FIN;
        end else begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.hit) begin
          state_d = S_FAIL;
        end else if (sts_i.scan_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.rec_last = sts_i.emit_last && !eof_q;
          if (sts_i.emit_last) begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (eof_q) begin
          state_d = S_ACC;
        end else begin
          cmd_o.line_inc = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_ACC: begin
        if (sts_i.out_free) begin
          cmd_o.ld_acc = 1'b1;
          cmd_o.clear  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_FAIL: begin
        if (sts_i.out_free) begin
          cmd_o.ld_err = 1'b1;
          cmd_o.clear  = eof_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      eof_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      eof_q   <= eof_d;
    end
  end

endmodule

// ----- rtl/core/hpl_dp.sv -----
module hpl_dp import hpl_pkg::*; #(
  parameter int MAX_LINE_BYTES = 32,
  parameter int MAX_RECORDS    = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        mode_i,
  input  logic [7:0]  text_byte_i,
  input  hpl_cmd_t    cmd_i,
  output hpl_sts_t    sts_o,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic [1:0]  kind_o,
  output logic [31:0] patch_address_o,
  output logic [7:0]  old_byte_o,
  output logic [7:0]  new_byte_o,
  output logic [15:0] line_number_o,
  output logic        last_o
);

  localparam int CW   = $clog2(MAX_LINE_BYTES + 1);
  localparam int IW   = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
  localparam int NW   = $clog2(MAX_RECORDS + 1);
  localparam int SW   = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int SUMW = ((NW > CW) ? NW : CW) + 1;

  localparam logic [3:0] PH_START   = 4'd0;
  localparam logic [3:0] PH_DSIGN   = 4'd1;
  localparam logic [3:0] PH_DDIGITS = 4'd2;
  localparam logic [3:0] PH_ADIGITS = 4'd3;
  localparam logic [3:0] PH_COLON   = 4'd4;
  localparam logic [3:0] PH_OLD_HI  = 4'd5;
  localparam logic [3:0] PH_OLD_LO  = 4'd6;
  localparam logic [3:0] PH_NEW_HI  = 4'd7;
  localparam logic [3:0] PH_NEW_LO  = 4'd8;
  localparam logic [3:0] PH_TRAIL   = 4'd9;
  localparam logic [3:0] PH_COMMENT = 4'd12;

  localparam logic [1:0] LT_BLANK = 2'd0;
  localparam logic [1:0] LT_DELTA = 2'd1;
  localparam logic [1:0] LT_PATCH = 2'd2;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [3:0] MAX_DIGITS = 4'd8;

  logic [31:0]   delta_q, delta_d;
  logic [15:0]   line_q, line_d;
  logic [3:0]    phase_q, phase_d;
  logic [31:0]   acc_q, acc_d;
  logic [3:0]    dcnt_q, dcnt_d;
  logic [3:0]    nib_q, nib_d;
  logic          neg_q, neg_d;
  logic [CW-1:0] ocnt_q, ocnt_d;
  logic [CW-1:0] ncnt_q, ncnt_d;
  logic          acr_q, acr_d;
  logic          err_q;
  logic [NW-1:0] seen_cnt_q;
  logic [31:0]   base_q;
  logic [NW-1:0] scan_q;
  logic [31:0]   rd_q;
  logic          rd_vld_q;
  logic [CW-1:0] emit_q;

  logic [7:0]  old_mem [MAX_LINE_BYTES];
  logic [7:0]  new_mem [MAX_LINE_BYTES];
  logic [31:0] seen_mem [MAX_RECORDS];

  logic        out_valid_q;
  logic [1:0]  kind_q;
  logic [31:0] addr_q;
  logic [7:0]  old_byte_q, new_byte_q;
  logic [15:0] line_out_q;
  logic        last_q;

  logic [7:0]  c;
  logic        is_hex, is_sp, is_eol;
  logic [3:0]  hexv;
  logic        do_trail, old_we, new_we;
  logic [1:0]  ltype;
  logic [7:0]  wbyte;
  hpl_ev_e     ev;
  logic [15:0] line_inc;
  logic        issue, out_free, load;
  logic [31:0] diff;

  assign c = text_byte_i;

  always_comb begin
    is_hex = 1'b1;
    hexv   = 4'd0;
    if (c >= "0" && c <= "9") begin
      hexv = 4'(c - "0");
    end else if (c >= "A" && c <= "F") begin
      hexv = 4'(c - "A" + 8'd10);
    end else if (c >= "a" && c <= "f") begin
      hexv = 4'(c - "a" + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign is_sp    = (c == CH_SPACE) || (c == CH_TAB);
  assign is_eol   = (c == CH_CR) || (c == CH_LF);
  assign line_inc = (line_q == 16'hFFFF) ? line_q : line_q + 16'd1;
  assign wbyte    = {nib_q, hexv};

  // one byte or the end of file, for the parser
  always_comb begin
    delta_d  = delta_q;
    line_d   = line_q;
    phase_d  = phase_q;
    acc_d    = acc_q;
    dcnt_d   = dcnt_q;
    nib_d    = nib_q;
    neg_d    = neg_q;
    ocnt_d   = ocnt_q;
    ncnt_d   = ncnt_q;
    acr_d    = acr_q;
    do_trail = 1'b0;
    ltype    = LT_BLANK;
    old_we   = 1'b0;
    new_we   = 1'b0;
    ev       = EV_NONE;
    if (!mode_i) begin
      acr_d = 1'b0;
      if (err_q) begin
        ev = EV_NONE;
      end else if (acr_q && (c == CH_LF) && (phase_q == PH_START)) begin
        ev = EV_NONE;
      end else begin
        case (phase_q)
          PH_START: begin
            if (c == CH_PLUS || c == CH_MINUS) begin
              neg_d   = (c == CH_MINUS);
              acc_d   = '0;
              dcnt_d  = '0;
              phase_d = PH_DSIGN;
            end else if (is_hex) begin
              acc_d   = 32'(hexv);
              dcnt_d  = 4'd1;
              phase_d = PH_ADIGITS;
            end else begin
              do_trail = 1'b1;
            end
          end
          PH_DSIGN: begin
            if (!is_hex) begin
              ev = EV_FAIL;
            end else begin
              acc_d   = 32'(hexv);
              dcnt_d  = 4'd1;
              phase_d = PH_DDIGITS;
            end
          end
          PH_DDIGITS: begin
            if (is_hex && dcnt_q < MAX_DIGITS) begin
              acc_d  = {acc_q[27:0], hexv};
              dcnt_d = dcnt_q + 4'd1;
            end else begin
              do_trail = 1'b1;
              ltype    = LT_DELTA;
            end
          end
          PH_ADIGITS: begin
            if (is_hex && dcnt_q < MAX_DIGITS) begin
              acc_d  = {acc_q[27:0], hexv};
              dcnt_d = dcnt_q + 4'd1;
            end else if (c == CH_COLON) begin
              phase_d = PH_COLON;
            end else begin
              ev = EV_FAIL;
            end
          end
          PH_COLON: begin
            if (c != CH_SPACE) begin
              ev = EV_FAIL;
            end else begin
              ocnt_d  = '0;
              phase_d = PH_OLD_HI;
            end
          end
          PH_OLD_HI: begin
            if (is_hex) begin
              if (ocnt_q >= CW'(MAX_LINE_BYTES)) begin
                ev = EV_FAIL;
              end else begin
                nib_d   = hexv;
                phase_d = PH_OLD_LO;
              end
            end else if (c == CH_SPACE) begin
              ncnt_d  = '0;
              phase_d = (ocnt_q != '0) ? PH_NEW_HI : PH_TRAIL + 4'(LT_PATCH);
            end else begin
              ev = EV_FAIL;
            end
          end
          PH_OLD_LO: begin
            if (!is_hex || ocnt_q >= CW'(MAX_LINE_BYTES)) begin
              ev = EV_FAIL;
            end else begin
              old_we  = 1'b1;
              ocnt_d  = ocnt_q + 1'b1;
              phase_d = PH_OLD_HI;
            end
          end
          PH_NEW_HI: begin
            if (!is_hex) begin
              ev = EV_FAIL;
            end else begin
              nib_d   = hexv;
              phase_d = PH_NEW_LO;
            end
          end
          PH_NEW_LO: begin
            if (!is_hex || ncnt_q >= CW'(MAX_LINE_BYTES)) begin
              ev = EV_FAIL;
            end else begin
              new_we  = 1'b1;
              ncnt_d  = ncnt_q + 1'b1;
              phase_d = ({1'b0, ncnt_q} + 1'b1 >= {1'b0, ocnt_q}) ?
                        PH_TRAIL + 4'(LT_PATCH) : PH_NEW_HI;
            end
          end
          PH_TRAIL + 4'(LT_BLANK), PH_TRAIL + 4'(LT_DELTA), PH_TRAIL + 4'(LT_PATCH): begin
            do_trail = 1'b1;
            ltype    = 2'(phase_q - PH_TRAIL);
          end
          PH_COMMENT + 4'(LT_BLANK), PH_COMMENT + 4'(LT_DELTA),
          PH_COMMENT + 4'(LT_PATCH): begin
            do_trail = is_eol;
            ltype    = 2'(phase_q - PH_COMMENT);
          end
          default: ev = EV_FAIL;
        endcase
      end
      // blanks, comment start or line end after a complete line body
      if (do_trail) begin
        if (is_sp) begin
          phase_d = PH_TRAIL + 4'(ltype);
        end else if (c == CH_SEMI) begin
          phase_d = PH_COMMENT + 4'(ltype);
        end else if (is_eol) begin
          phase_d = PH_START;
          acr_d   = (c == CH_CR);
          if (ltype == LT_PATCH) begin
            ev = EV_PATCH;
          end else begin
            line_d = line_inc;
            if (ltype == LT_DELTA) begin
              delta_d = neg_q ? (32'd0 - acc_q) : acc_q;
            end
          end
        end else begin
          ev = EV_FAIL;
        end
      end
    end else begin
      // end of file
      if (err_q) begin
        ev = EV_SILENT;
      end else begin
        case (phase_q)
          PH_START, PH_DDIGITS, PH_TRAIL + 4'(LT_BLANK), PH_TRAIL + 4'(LT_DELTA),
          PH_COMMENT + 4'(LT_BLANK), PH_COMMENT + 4'(LT_DELTA): ev = EV_ACCEPT;
          PH_TRAIL + 4'(LT_PATCH), PH_COMMENT + 4'(LT_PATCH): ev = EV_PATCH;
          default: ev = EV_FAIL;
        endcase
      end
    end
  end

  assign issue    = cmd_i.scan_en && (scan_q < seen_cnt_q);
  assign diff     = rd_q - base_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign load     = cmd_i.emit || cmd_i.ld_err || cmd_i.ld_acc;

  always_comb begin
    sts_o            = '0;
    sts_o.ev         = ev;
    sts_o.full       = (SUMW'(seen_cnt_q) + SUMW'(ocnt_q)) > SUMW'(MAX_RECORDS);
    sts_o.zero_pairs = (ocnt_q == '0);
    sts_o.hit        = rd_vld_q && (diff < 32'(ocnt_q));
    sts_o.scan_done  = !rd_vld_q && !(scan_q < seen_cnt_q);
    sts_o.emit_last  = ({1'b0, emit_q} + 1'b1) == {1'b0, ocnt_q};
    sts_o.out_free   = out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q    <= '0;
      line_q     <= 16'd1;
      phase_q    <= PH_START;
      acc_q      <= '0;
      dcnt_q     <= '0;
      nib_q      <= '0;
      neg_q      <= 1'b0;
      ocnt_q     <= '0;
      ncnt_q     <= '0;
      acr_q      <= 1'b0;
      err_q      <= 1'b0;
      seen_cnt_q <= '0;
      scan_q     <= '0;
      rd_vld_q   <= 1'b0;
      emit_q     <= '0;
    end else begin
      rd_vld_q <= issue;
      if (cmd_i.clear) begin
        delta_q    <= '0;
        line_q     <= 16'd1;
        phase_q    <= PH_START;
        acc_q      <= '0;
        dcnt_q     <= '0;
        nib_q      <= '0;
        neg_q      <= 1'b0;
        ocnt_q     <= '0;
        ncnt_q     <= '0;
        acr_q      <= 1'b0;
        err_q      <= 1'b0;
        seen_cnt_q <= '0;
      end else begin
        if (cmd_i.step) begin
          delta_q <= delta_d;
          line_q  <= line_d;
          phase_q <= phase_d;
          acc_q   <= acc_d;
          dcnt_q  <= dcnt_d;
          nib_q   <= nib_d;
          neg_q   <= neg_d;
          ocnt_q  <= ocnt_d;
          ncnt_q  <= ncnt_d;
          acr_q   <= acr_d;
        end
        if (cmd_i.line_inc) begin
          line_q <= line_inc;
        end
        if (cmd_i.ld_err) begin
          err_q <= 1'b1;
        end
        if (cmd_i.emit) begin
          seen_cnt_q <= seen_cnt_q + 1'b1;
        end
      end
      if (cmd_i.chk) begin
        scan_q <= '0;
        emit_q <= '0;
      end else begin
        if (issue) begin
          scan_q <= scan_q + 1'b1;
        end
        if (cmd_i.emit) begin
          emit_q <= emit_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.chk) begin
      base_q <= acc_q + delta_q;
    end
    if (cmd_i.step && old_we) begin
      old_mem[ocnt_q[IW-1:0]] <= wbyte;
    end
    if (cmd_i.step && new_we) begin
      new_mem[ncnt_q[IW-1:0]] <= wbyte;
    end
  end

  // address table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      seen_mem[seen_cnt_q[SW-1:0]] <= base_q + 32'(emit_q);
    end
    if (issue) begin
      rd_q <= seen_mem[scan_q[SW-1:0]];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (cmd_i.emit) begin
        kind_q     <= KIND_RECORD;
        addr_q     <= base_q + 32'(emit_q);
        old_byte_q <= old_mem[emit_q[IW-1:0]];
        new_byte_q <= new_mem[emit_q[IW-1:0]];
        line_out_q <= '0;
        last_q     <= cmd_i.rec_last;
      end else begin
        kind_q     <= cmd_i.ld_err ? KIND_ERROR : KIND_ACCEPT;
        addr_q     <= '0;
        old_byte_q <= '0;
        new_byte_q <= '0;
        line_out_q <= cmd_i.ld_err ? line_q : 16'd0;
        last_q     <= 1'b1;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign patch_address_o = addr_q;
  assign old_byte_o      = old_byte_q;
  assign new_byte_o      = new_byte_q;
  assign line_number_o   = line_out_q;
  assign last_o          = last_q;

endmodule

// ----- rtl/core/hex_patch_line_parser_core.sv -----
// channel  direction  handshake               payload
// in       input      in_valid_i / in_stall_o  mode_i, text_byte_i
// out      output     out_valid_o / out_stall_i kind_o, patch_address_o, old_byte_o,
//                                              new_byte_o, line_number_o, last_o
//
// an ordinary text byte leaves the sequencer idle, ready for the next byte while the output is free
// a patch line end then holds the input through a check, a scan of the address table, one
// record out per byte pair and a closing step; with no pairs the scan and records are
// skipped; end of file then adds the accept result
// rst_ni is asynchronous; the address table has no reset, a fill count covers it
// a stalled output holds the block after the current item; items wait meanwhile
module hex_patch_line_parser_core import hpl_pkg::*; #(
  parameter int MAX_LINE_BYTES = 32,
  parameter int MAX_RECORDS    = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  text_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [31:0] patch_address_o,
  output logic [7:0]  old_byte_o,
  output logic [7:0]  new_byte_o,
  output logic [15:0] line_number_o,
  output logic        last_o
);

  hpl_cmd_t cmd;
  hpl_sts_t sts;

  // sequencer: byte step, duplicate scan, record emission, final result
  hpl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // parser registers, line byte stores, address table and output register
  hpl_dp #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES),
    .MAX_RECORDS    (MAX_RECORDS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mode_i          (mode_i),
    .text_byte_i     (text_byte_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .kind_o          (kind_o),
    .patch_address_o (patch_address_o),
    .old_byte_o      (old_byte_o),
    .new_byte_o      (new_byte_o),
    .line_number_o   (line_number_o),
    .last_o          (last_o)
  );

  // an item is only taken when the output register can take its result
  a_accept_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !(out_valid_o && out_stall_i))
    else $error("item accepted while output blocked");

  // errors and accepts always close the item
  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o != KIND_RECORD)) |-> last_o)
    else $error("final result without last");

  // an error names a real line
  a_err_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KIND_ERROR)) |-> (line_number_o != 16'd0))
    else $error("error with line zero");

endmodule

// ----- bench/tb_hex_patch_line_parser_core.sv -----
module tb_hex_patch_line_parser_core;
  import hpl_pkg::*;

  localparam int LINE_BYTES = 32;
  localparam int TABLE_SIZE = 16;  // small table so the full-table case is reachable
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 80;

  // parser phases, mirrored from the block's behavior
  localparam int PH_START   = 0;
  localparam int PH_DSIGN   = 1;
  localparam int PH_DDIGITS = 2;
  localparam int PH_ADIGITS = 3;
  localparam int PH_COLON   = 4;
  localparam int PH_OLD_HI  = 5;
  localparam int PH_OLD_LO  = 6;
  localparam int PH_NEW_HI  = 7;
  localparam int PH_NEW_LO  = 8;
  localparam int PH_TRAIL   = 9;
  localparam int PH_COMMENT = 12;
  localparam int LT_BLANK = 0;
  localparam int LT_DELTA = 1;
  localparam int LT_PATCH = 2;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_EOF  = 1'b1;

  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [7:0]  old_b;
    logic [7:0]  new_b;
    logic [15:0] line;
    logic        last;
  } patch_result_t;

  class hex_patch_board;
    patch_result_t pending_q[$];
    patch_result_t step_q[$];
    int errors;
    int n_records;
    int n_accepts;
    int n_fails;
    logic [31:0] delta;
    logic [15:0] line_no;
    int          phase;
    logic [31:0] acc;
    int          ndig;
    logic [3:0]  nib;
    logic        neg;
    logic [7:0]  old_mem[LINE_BYTES];
    logic [7:0]  new_mem[LINE_BYTES];
    int          old_cnt;
    int          new_cnt;
    logic [31:0] seen[TABLE_SIZE];
    int          seen_cnt;
    logic        err_done;
    logic        after_cr;

    function new();
      errors = 0;
      n_records = 0;
      n_accepts = 0;
      n_fails = 0;
      clear_file();
    endfunction

    function void clear_file();
      delta = 0;
      line_no = 1;
      phase = PH_START;
      acc = 0;
      ndig = 0;
      nib = 0;
      neg = 0;
      old_cnt = 0;
      new_cnt = 0;
      seen_cnt = 0;
      err_done = 0;
      after_cr = 0;
    endfunction

    function int hexval(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - 48;
      if (c >= "A" && c <= "F") return int'(c) - 55;
      if (c >= "a" && c <= "f") return int'(c) - 87;
      return -1;
    endfunction

    function void emit(logic [1:0] k, logic [31:0] a, logic [7:0] ob, logic [7:0] nb,
                       logic [15:0] ln);
      patch_result_t r;
      r.kind = k;
      r.addr = a;
      r.old_b = ob;
      r.new_b = nb;
      r.line = ln;
      r.last = 1'b0;
      step_q.push_back(r);
    endfunction

    function void raise_error();
      err_done = 1;
      emit(KIND_ERROR, 0, 0, 0, line_no);
    endfunction

    function int line_kind();
      case (phase)
        PH_START, PH_TRAIL + LT_BLANK, PH_COMMENT + LT_BLANK: return LT_BLANK;
        PH_DDIGITS, PH_TRAIL + LT_DELTA, PH_COMMENT + LT_DELTA: return LT_DELTA;
        PH_TRAIL + LT_PATCH, PH_COMMENT + LT_PATCH: return LT_PATCH;
        default: return -1;
      endcase
    endfunction

    function void close_line(int t);
      logic [31:0] a;
      if (t == LT_DELTA) begin
        delta = neg ? (32'd0 - acc) : acc;
      end else if (t == LT_PATCH) begin
        if (old_cnt > LINE_BYTES || seen_cnt + old_cnt > TABLE_SIZE) begin
          raise_error();
          return;
        end
        for (int j = 0; j < old_cnt; j++) begin
          a = acc + j + delta;
          for (int m = 0; m < seen_cnt; m++) begin
            if (seen[m] == a) begin
              raise_error();
              return;
            end
          end
        end
        for (int j = 0; j < old_cnt; j++) begin
          a = acc + j + delta;
          seen[seen_cnt] = a;
          seen_cnt++;
          emit(KIND_RECORD, a, old_mem[j], new_mem[j], 0);
        end
      end
      phase = PH_START;
      if (line_no < 16'hFFFF) line_no++;
    endfunction

    // blanks, comment start or line end after a complete body
    function void tail(logic [7:0] c, int t);
      if (c == " " || c == 8'd9) begin
        phase = PH_TRAIL + t;
      end else if (c == ";") begin
        phase = PH_COMMENT + t;
      end else if (c == CH_CR || c == CH_LF) begin
        close_line(t);
        if (!err_done && c == CH_CR) after_cr = 1;
      end else begin
        raise_error();
      end
    endfunction

    function void take(logic [7:0] c);
      int h;
      h = hexval(c);
      if (after_cr) begin
        after_cr = 0;
        if (c == CH_LF && phase == PH_START) return;
      end
      case (phase)
        PH_START: begin
          if (c == "+" || c == "-") begin
            neg = (c == "-");
            acc = 0;
            ndig = 0;
            phase = PH_DSIGN;
          end else if (h >= 0) begin
            acc = 32'(h);
            ndig = 1;
            phase = PH_ADIGITS;
          end else begin
            tail(c, LT_BLANK);
          end
        end
        PH_DSIGN: begin
          if (h < 0) begin
            raise_error();
          end else begin
            acc = 32'(h);
            ndig = 1;
            phase = PH_DDIGITS;
          end
        end
        PH_DDIGITS: begin
          if (h >= 0 && ndig < 8) begin
            acc = (acc << 4) | h;
            ndig++;
          end else begin
            tail(c, LT_DELTA);
          end
        end
        PH_ADIGITS: begin
          if (h >= 0 && ndig < 8) begin
            acc = (acc << 4) | h;
            ndig++;
          end else if (c == ":") begin
            phase = PH_COLON;
          end else begin
            raise_error();
          end
        end
        PH_COLON: begin
          if (c != " ") begin
            raise_error();
          end else begin
            old_cnt = 0;
            phase = PH_OLD_HI;
          end
        end
        PH_OLD_HI: begin
          if (h >= 0) begin
            if (old_cnt >= LINE_BYTES) begin
              raise_error();
            end else begin
              nib = 4'(h);
              phase = PH_OLD_LO;
            end
          end else if (c == " ") begin
            new_cnt = 0;
            phase = (old_cnt != 0) ? PH_NEW_HI : PH_TRAIL + LT_PATCH;
          end else begin
            raise_error();
          end
        end
        PH_OLD_LO: begin
          if (h < 0 || old_cnt >= LINE_BYTES) begin
            raise_error();
          end else begin
            old_mem[old_cnt] = {nib, 4'(h)};
            old_cnt++;
            phase = PH_OLD_HI;
          end
        end
        PH_NEW_HI: begin
          if (h < 0) begin
            raise_error();
          end else begin
            nib = 4'(h);
            phase = PH_NEW_LO;
          end
        end
        PH_NEW_LO: begin
          if (h < 0 || new_cnt >= LINE_BYTES) begin
            raise_error();
          end else begin
            new_mem[new_cnt] = {nib, 4'(h)};
            new_cnt++;
            phase = (new_cnt >= old_cnt) ? PH_TRAIL + LT_PATCH : PH_NEW_HI;
          end
        end
        PH_TRAIL + LT_BLANK: tail(c, LT_BLANK);
        PH_TRAIL + LT_DELTA: tail(c, LT_DELTA);
        PH_TRAIL + LT_PATCH: tail(c, LT_PATCH);
        PH_COMMENT + LT_BLANK, PH_COMMENT + LT_DELTA, PH_COMMENT + LT_PATCH: begin
          if (c == CH_CR || c == CH_LF) tail(c, phase - PH_COMMENT);
        end
        default: raise_error();
      endcase
    endfunction

    // an accepted input item: work out what it should produce
    function void note_item(logic mode, logic [7:0] c);
      int t;
      step_q.delete();
      if (mode == MODE_BYTE) begin
        if (!err_done) take(c);
      end else begin
        if (!err_done) begin
          if (phase == PH_START) begin
            emit(KIND_ACCEPT, 0, 0, 0, 0);
          end else begin
            t = line_kind();
            if (t < 0) begin
              raise_error();
            end else begin
              close_line(t);
              if (!err_done) emit(KIND_ACCEPT, 0, 0, 0, 0);
            end
          end
        end
        clear_file();
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      foreach (step_q[i]) pending_q.push_back(step_q[i]);
    endfunction

    task report(string what, logic [31:0] want, logic [31:0] got);
      $display("mismatch %s: expected %0h got %0h", what, want, got);
      errors++;
    endtask

    task check_result(patch_result_t got);
      patch_result_t want;
      if (pending_q.size() == 0) begin
        report("unexpected result kind", 0, got.kind);
        return;
      end
      want = pending_q.pop_front();
      if (got.kind != want.kind) report("kind", want.kind, got.kind);
      if (got.addr != want.addr) report("patch_address", want.addr, got.addr);
      if (got.old_b != want.old_b) report("old_byte", want.old_b, got.old_b);
      if (got.new_b != want.new_b) report("new_byte", want.new_b, got.new_b);
      if (got.line != want.line) report("line_number", want.line, got.line);
      if (got.last != want.last) report("last", want.last, got.last);
      case (want.kind)
        KIND_RECORD: n_records++;
        KIND_ACCEPT: n_accepts++;
        default: n_fails++;
      endcase
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode = MODE_BYTE;
  logic [7:0]  text_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [31:0] patch_address;
  logic [7:0]  old_byte;
  logic [7:0]  new_byte;
  logic [15:0] line_number;
  logic        last;

  hex_patch_board board = new();
  logic [7:0] text_q[$];
  int  sent_items = 0;
  bit  calm = 0;     // no idling on either side while set
  int  idle_cycles = 0;

  always #2 clk = ~clk;

  hex_patch_line_parser_core #(
    .MAX_LINE_BYTES(LINE_BYTES),
    .MAX_RECORDS(TABLE_SIZE)
  ) DUT (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .mode_i(mode),
    .text_byte_i(text_byte),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .kind_o(kind),
    .patch_address_o(patch_address),
    .old_byte_o(old_byte),
    .new_byte_o(new_byte),
    .line_number_o(line_number),
    .last_o(last)
  );

  function bit idle_now();
    return !calm && ($urandom_range(99) < 21);
  endfunction

  // monitor: both channels sampled at the rising edge, inputs move on the falling edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_item(mode, text_byte);
      if (out_valid && !out_stall)
        board.check_result('{kind, patch_address, old_byte, new_byte, line_number, last});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  always @(negedge clk) out_stall <= idle_now();

  task send_item(logic m, logic [7:0] c);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    text_byte <= c;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent_items++;
  endtask

  task flush_text();
    foreach (text_q[i]) send_item(MODE_BYTE, text_q[i]);
    text_q.delete();
  endtask

  task push_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  function logic [7:0] hex_char(logic [3:0] n);
    if (n < 10) return 8'd48 + n;
    return ($urandom_range(1) ? 8'd55 : 8'd87) + n;
  endfunction

  task push_hex(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) text_q.push_back(hex_char(v[i*4 +: 4]));
  endtask

  task push_eol();
    case ($urandom_range(2))
      0: text_q.push_back(CH_CR);
      1: text_q.push_back(CH_LF);
      default: begin
        text_q.push_back(CH_CR);
        text_q.push_back(CH_LF);
      end
    endcase
  endtask

  task push_tail();
    int n;
    if ($urandom_range(9) < 3) begin
      n = $urandom_range(1, 3);
      repeat (n) text_q.push_back($urandom_range(1) ? 8'd32 : 8'd9);
    end
    if ($urandom_range(9) < 2) begin
      text_q.push_back(";");
      n = $urandom_range(0, 5);
      repeat (n) text_q.push_back(8'($urandom_range(255)) | 8'h80);
      text_q.push_back(8'($urandom_range(9)));  // low bytes, NUL included, in the comment
    end
  endtask

  task push_patch_line(int pairs);
    logic [31:0] a;
    a = $urandom_range(1) ? 32'($urandom_range(31)) : $urandom;
    push_hex(a, $urandom_range(1, 8));
    push_str(": ");
    for (int i = 0; i < pairs; i++) push_hex($urandom, 2);
    text_q.push_back(" ");
    for (int i = 0; i < pairs; i++) push_hex($urandom, 2);
  endtask

  // one random file: mostly well-formed lines, a few broken ones
  task random_file();
    int lines;
    int kind_sel;
    int pos;
    int ndig;
    lines = $urandom_range(1, 6);
    for (int l = 0; l < lines; l++) begin
      kind_sel = $urandom_range(99);
      if (kind_sel < 20) begin
        if ($urandom_range(1)) text_q.push_back(8'd9);
        push_tail();
      end else if (kind_sel < 40) begin
        text_q.push_back($urandom_range(1) ? "+" : "-");
        ndig = ($urandom_range(19) == 0) ? 9 : $urandom_range(1, 8);
        // a ninth digit makes the delta too long
        if (ndig > 8) push_hex($urandom, 1);
        push_hex($urandom, (ndig > 8) ? 8 : ndig);
        push_tail();
      end else begin
        push_patch_line(($urandom_range(19) == 0) ? $urandom_range(30, 33)
                                                  : $urandom_range(0, 3));
        push_tail();
      end
      if ($urandom_range(9) == 0 && text_q.size() > 0) begin
        pos = $urandom_range(text_q.size() - 1);
        text_q[pos] = 8'($urandom_range(255));
      end
      if (l < lines - 1 || $urandom_range(1)) push_eol();
    end
    flush_text();
    send_item(MODE_EOF, 8'($urandom_range(255)));
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    while (board.pending_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // blank, comment holding a NUL, CR-LF, maximal delta, zero-pair patch line
    push_str(" ;c");
    text_q.push_back(8'd0);
    push_eol();
    push_str("+FFFFFFFF");
    text_q.push_back(CH_CR);
    text_q.push_back(CH_LF);
    push_str("0: 00 FF\t");
    text_q.push_back(CH_CR);
    push_str("10:  ");
    flush_text();
    send_item(MODE_EOF, 8'hFF);
    // ninth address digit, then bytes that are ignored, then a silent end of file
    push_str("123456789:x");
    flush_text();
    send_item(MODE_EOF, 8'h00);
    // delta closed by end of file, bare NUL line, duplicate address
    push_str("-1");
    flush_text();
    send_item(MODE_EOF, 8'h00);
    text_q.push_back(8'd0);
    flush_text();
    send_item(MODE_EOF, 8'h00);
    push_str("1: 01 02\n1: 03 04\n");
    flush_text();
    send_item(MODE_EOF, 8'h00);
    // line store overflow
    push_patch_line(33);
    flush_text();
    send_item(MODE_EOF, 8'h00);
    wait_drained();

    while (sent_items < 480) begin
      calm = (sent_items > 200 && sent_items < 320);
      if ($urandom_range(9) == 0) wait_drained();
      random_file();
    end
    calm = 0;
    wait_drained();

    $display("sent %0d items over random files; checked %0d records, %0d accepts, %0d errors",
             sent_items, board.n_records, board.n_accepts, board.n_fails);
    if (board.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- hex_patch_line_parser_core.f -----
rtl/core/hpl_pkg.sv
rtl/core/hpl_ctrl.sv
rtl/core/hpl_dp.sv
rtl/core/hex_patch_line_parser_core.sv
bench/tb_hex_patch_line_parser_core.sv
